### rtl/packet_field_fnv1a_hash_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the packet field FNV-1a hash unit
// Shared wrappers for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_FIELD_FNV1A_HASH_UNIT_MACROS_SVH
`define PACKET_FIELD_FNV1A_HASH_UNIT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define PFH_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define PFH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define PFH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pfh_pkg.sv
// ----------------------------------------------------------------------------
// Packet field hash package
// Word types, configuration layout and the FNV-1a 64 step function.
// ----------------------------------------------------------------------------
package pfh_pkg;

  localparam int DATA_W  = 8;
  localparam int LEN_W   = 12;
  localparam int MASK_W  = 8;
  localparam int HASH_W  = 64;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_PACKET_DEF = 2048;
  localparam int QDEPTH = 4;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_MASK   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_HASH = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  packet_length;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    logic [HASH_W-1:0] field_hash;
    logic              field_valid;
  } out_word_t;

  typedef struct packed {
    logic signed [LEN_W-1:0] field_offset;
    logic [LEN_W-1:0]        field_length;
    logic [MASK_W-1:0]       field_mask;
    logic [HASH_W-1:0]       initial_hash;
  } cfg_t;

  // One classified byte handed from the front end to the hash engine.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              in_window;
    logic              first;
    logic              last_pkt;
    logic              res_valid;
  } op_t;

  // Xor the byte in, then multiply by the prime 2^40 + 0x1b3 as shifted adds.
  function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                 input logic [DATA_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-DATA_W){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### rtl/pfh_queue.sv
// ----------------------------------------------------------------------------
// Packet field hash queue
// Short FIFO of classified bytes between the front end and the hash engine.
// ----------------------------------------------------------------------------
`include "packet_field_fnv1a_hash_unit_macros.svh"

module pfh_queue
  import pfh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  op_t            mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full       = (count == QCW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCW'(1);
        2'b01:   count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

  `PFH_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= QCW'(QDEPTH), "queue count overflow")
  `PFH_ASSERT_IMPL(a_pop_nonempty, clk, rst, pop, count != '0, "pop from empty queue")
  `PFH_ASSERT_NEXT(a_push_count, clk, rst, push && !pop, count == $past(count) + QCW'(1), "push lost")

endmodule

### rtl/pfh_front.sv
// ----------------------------------------------------------------------------
// Packet field hash front end
// Tracks the byte position and classifies each byte against the window.
// ----------------------------------------------------------------------------
module pfh_front
  import pfh_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     full,
  output logic     push,
  output op_t      push_op
);

  localparam int POS_W = $clog2(MAX_PACKET + 1);
  localparam int CW    = ((POS_W + 1) > (LEN_W + 3)) ? (POS_W + 1) : (LEN_W + 3);

  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_next;
  logic [POS_W-1:0]     seen;
  logic                 below_max;
  logic signed [CW-1:0] off_s;
  logic signed [CW-1:0] plen_s;
  logic signed [CW-1:0] flen_s;
  logic signed [CW-1:0] start_s;
  logic signed [CW-1:0] end_s;
  logic signed [CW-1:0] pos_s;
  logic signed [CW-1:0] pos1_s;
  logic signed [CW-1:0] seen_s;
  logic                 len_nz;

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    below_max = (pos < POS_W'(MAX_PACKET));
    seen      = below_max ? pos + POS_W'(1) : pos;
    off_s     = {{(CW-LEN_W){cfg.field_offset[LEN_W-1]}}, cfg.field_offset};
    plen_s    = {{(CW-LEN_W){1'b0}}, in_data.packet_length};
    flen_s    = {{(CW-LEN_W){1'b0}}, cfg.field_length};
    pos_s     = {{(CW-POS_W){1'b0}}, pos};
    pos1_s    = pos_s + {{(CW-1){1'b0}}, 1'b1};
    seen_s    = {{(CW-POS_W){1'b0}}, seen};
    start_s   = off_s[CW-1] ? off_s + plen_s : off_s;
    end_s     = start_s + flen_s;
    len_nz    = (cfg.field_length != '0);

    push_op.in_window = below_max && len_nz && (pos_s >= start_s) && (pos_s < end_s);
    push_op.first     = (pos_s == start_s);
    push_op.data      = (pos1_s == end_s) ? (in_data.data_byte & cfg.field_mask)
                                          : in_data.data_byte;
    push_op.last_pkt  = in_data.last_byte;
    push_op.res_valid = !start_s[CW-1] && len_nz && (end_s <= plen_s) && (end_s <= seen_s);

    pos_next = pos;
    if (push) begin
      pos_next = in_data.last_byte ? '0 : seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

### rtl/pfh_back.sv
// ----------------------------------------------------------------------------
// Packet field hash engine
// Folds classified bytes into the FNV-1a 64 hash and registers the result.
// ----------------------------------------------------------------------------
`include "packet_field_fnv1a_hash_unit_macros.svh"

module pfh_back
  import pfh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [HASH_W-1:0] initial_hash,
  input  logic              head_valid,
  input  op_t               head_op,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_data
);

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  logic [HASH_W-1:0] seed;
  logic [HASH_W-1:0] hash_new;
  logic              emit;

  always_comb begin
    pop  = head_valid && (!head_op.last_pkt || !out_valid || !out_stall);
    emit = pop && head_op.last_pkt;
    seed = head_op.first ? initial_hash : running_hash;
    hash_new = head_op.in_window ? fnv_step(seed, head_op.data) : running_hash;
    running_hash_next = running_hash;
    if (pop) begin
      running_hash_next = head_op.last_pkt ? initial_hash : hash_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
      out_valid    <= 1'b0;
    end else begin
      running_hash <= running_hash_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.field_hash  <= head_op.res_valid ? hash_new : '0;
      out_data.field_valid <= head_op.res_valid;
    end
  end

  `PFH_ASSERT_IMPL(a_rose_from_emit, clk, rst, $rose(out_valid), $past(emit), "result without packet end")
  `PFH_ASSERT_IMPL(a_invalid_zero, clk, rst, out_valid && !out_data.field_valid, out_data.field_hash == '0, "invalid result has nonzero hash")

endmodule

### rtl/packet_field_fnv1a_hash_unit.sv
// ----------------------------------------------------------------------------
// Packet field FNV-1a hash unit
// Hashes a configured byte window of each packet with 64-bit FNV-1a.
// ----------------------------------------------------------------------------
// Packet bytes enter on the input channel one word at a time (in_valid,
// in_stall, in_data), each carrying the packet length and a last-byte flag.
// One result word leaves on the output channel (out_valid, out_stall,
// out_data) for every packet, after its last byte: the hash of the window and
// a valid flag, or hash zero with the flag cleared when the window does not
// fit inside the packet or has zero length.
// Throughput is one byte per cycle while in_stall is low; the engine's hash
// recurrence folds one byte per cycle unless a result is stalled. A four-entry
// queue separates byte classification from hashing, so a stalled result only
// backs up the input once the queue is full. Registers are written on the cfg
// channel, which is always ready; the user must write them only while no
// packet is in flight, not enforced by the block. Synchronous reset restores
// the register defaults, empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module packet_field_fnv1a_hash_unit
  import pfh_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HASH_W-1:0]    cfg_data
);

  cfg_t cfg;
  logic full;
  logic push;
  op_t  push_op;
  logic pop;
  logic head_valid;
  op_t  head_op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_offset <= '0;
      cfg.field_length <= LEN_W'(1);
      cfg.field_mask   <= '1;
      cfg.initial_hash <= FNV_BASIS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FIELD_OFFSET: cfg.field_offset <= signed'(cfg_data[LEN_W-1:0]);
        CFG_FIELD_LENGTH: cfg.field_length <= cfg_data[LEN_W-1:0];
        CFG_FIELD_MASK:   cfg.field_mask   <= cfg_data[MASK_W-1:0];
        CFG_INITIAL_HASH: cfg.initial_hash <= cfg_data;
        default:          cfg <= cfg;
      endcase
    end
  end

  pfh_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .push_op  (push_op)
  );

  pfh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  pfh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .initial_hash (cfg.initial_hash),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

endmodule
